[sv/flow_pulse_window_rate_unit_defines.svh]
// Assertion macros shared by the flow pulse window rate RTL.
// Each macro expects clk and rst_n in scope.
`ifndef FLOW_PULSE_WINDOW_RATE_UNIT_DEFINES_SVH
`define FLOW_PULSE_WINDOW_RATE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FPWR_ASSERT_NOW(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define FPWR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define FPWR_ASSERT_NOW(label, expr)

`define FPWR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/fpwr_pkg.sv]
`default_nettype none
package fpwr_pkg;

  localparam int WINDOW_SLOTS = 10;
  localparam int HIST_DEPTH   = WINDOW_SLOTS - 1;
  localparam int HSUM_W       = $clog2(HIST_DEPTH * 255 + 1);
  localparam int SUM_W        = $clog2(WINDOW_SLOTS * 255 + 1);

  localparam int OP_W     = 2;
  localparam int FILL_W   = 16;
  localparam int CNT_W    = 8;
  localparam int RATE_W   = 5;
  localparam int HOT_W    = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PULSE = 2'd0,
    OP_TICK  = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  typedef struct packed {
    logic pulse;
    logic tick;
  } fpwr_win_ctl_t;

  localparam logic [CNT_W-1:0] HZ_MIN   = 8'd5;
  localparam logic [CNT_W-1:0] HZ_LOW   = 8'd10;
  localparam logic [CNT_W-1:0] HZ_MID   = 8'd16;
  localparam logic [CNT_W-1:0] HZ_HIGH  = 8'd40;
  localparam logic [CNT_W-1:0] HZ_TOP   = 8'd118;
  localparam logic [CNT_W-1:0] CNT_MAX  = 8'd255;

  localparam logic [RATE_W-1:0] RATE_MAX = 5'd20;
  localparam logic [HOT_W-1:0]  HOT_MAX  = 11'd2000;

  typedef logic [HOT_W-1:0] hot_tab_t [24];
  localparam hot_tab_t HOT_MID_TAB = '{
    11'd300, 11'd320, 11'd340, 11'd360, 11'd380, 11'd390,
    11'd400, 11'd420, 11'd440, 11'd460, 11'd480, 11'd490,
    11'd500, 11'd520, 11'd540, 11'd560, 11'd580, 11'd590,
    11'd600, 11'd620, 11'd640, 11'd660, 11'd680, 11'd690
  };

  // x/6 for x < 128 via *43 >> 8
  function automatic logic [4:0] div6(input logic [6:0] x);
    logic [12:0] p;
    p = {6'd0, x} * 13'd43;
    return p[12:8];
  endfunction

  function automatic logic [RATE_W-1:0] rate_tenths(input logic [CNT_W-1:0] hz);
    logic [CNT_W-1:0] d;
    d = hz - HZ_LOW;
    if (hz < HZ_MIN)       return '0;
    else if (hz < HZ_LOW)  return 5'd1;
    else if (hz >= HZ_TOP) return RATE_MAX;
    else                   return 5'd2 + div6(d[6:0]);
  endfunction

  function automatic logic [HOT_W-1:0] hot_rate(input logic [CNT_W-1:0] hz);
    logic [CNT_W-1:0] dm;
    logic [CNT_W-1:0] dh;
    dm = hz - HZ_MID;
    dh = hz - HZ_HIGH;
    if (hz < HZ_MIN)       return 11'd0;
    else if (hz < HZ_LOW)  return 11'd100;
    else if (hz < HZ_MID)  return 11'd200;
    else if (hz < HZ_HIGH) return HOT_MID_TAB[dm[4:0]];
    else if (hz >= HZ_TOP) return HOT_MAX;
    else                   return 11'd700 + 11'(div6(dh[6:0])) * 11'd100;
  endfunction

endpackage
`default_nettype wire

[sv/fpwr_in_if.sv]
`default_nettype none
interface fpwr_in_if;
  import fpwr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [FILL_W-1:0] fill_value;
  logic              tray_filling_active;
  logic              hot_dispensing;
  logic              tray_pump_on;

  modport source (
    output valid, operation, fill_value, tray_filling_active, hot_dispensing,
           tray_pump_on,
    input  ready
  );

  modport sink (
    input  valid, operation, fill_value, tray_filling_active, hot_dispensing,
           tray_pump_on,
    output ready
  );
endinterface
`default_nettype wire

[sv/fpwr_out_if.sv]
`default_nettype none
interface fpwr_out_if;
  import fpwr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  pulses_per_second;
  logic [RATE_W-1:0] flow_tenths_lpm;
  logic [HOT_W-1:0]  hot_flow_value;
  logic [FILL_W-1:0] fill_remaining;

  modport source (
    output valid, pulses_per_second, flow_tenths_lpm, hot_flow_value, fill_remaining,
    input  ready
  );

  modport sink (
    input  valid, pulses_per_second, flow_tenths_lpm, hot_flow_value, fill_remaining,
    output ready
  );
endinterface
`default_nettype wire

[sv/fpwr_cell.sv]
`default_nettype none
module fpwr_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        shift_en,
  input  wire  [fpwr_pkg::CNT_W-1:0] d,
  output logic [fpwr_pkg::CNT_W-1:0] q
);
  import fpwr_pkg::*;

  logic [CNT_W-1:0] slot_r;
  logic [CNT_W-1:0] slot_nxt;

  always_comb begin
    slot_nxt = shift_en ? d : slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign q = slot_r;
endmodule
`default_nettype wire

[sv/fpwr_window.sv]
`default_nettype none
`include "flow_pulse_window_rate_unit_defines.svh"
module fpwr_window (
  input  wire                          clk,
  input  wire                          rst_n,
  input  fpwr_pkg::fpwr_win_ctl_t      ctl,
  output logic [fpwr_pkg::CNT_W-1:0]   sum_nxt
);
  import fpwr_pkg::*;

  logic [CNT_W-1:0]  slot_cnt_r;
  logic [CNT_W-1:0]  slot_cnt_nxt;
  logic [HSUM_W-1:0] hist_sum_r;
  logic [HSUM_W-1:0] hist_sum_nxt;
  logic [CNT_W-1:0]  last_sum_r;
  logic [SUM_W-1:0]  win_sum;
  logic [SUM_W-1:0]  hist_upd;
  logic [CNT_W-1:0]  tap [HIST_DEPTH];

  // newest slot enters cell 0, oldest drops out of the last cell
  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      fpwr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ctl.tick),
        .d        (slot_cnt_r),
        .q        (tap[i])
      );
    end else begin : g_body
      fpwr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ctl.tick),
        .d        (tap[i-1]),
        .q        (tap[i])
      );
    end
  end

  // running exact sum of the history cells
  always_comb begin
    win_sum  = SUM_W'(hist_sum_r) + SUM_W'(slot_cnt_r);
    hist_upd = win_sum - SUM_W'(tap[HIST_DEPTH-1]);

    slot_cnt_nxt = slot_cnt_r;
    hist_sum_nxt = hist_sum_r;
    sum_nxt      = last_sum_r;
    if (ctl.tick) begin
      slot_cnt_nxt = '0;
      hist_sum_nxt = hist_upd[HSUM_W-1:0];
      sum_nxt      = (win_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : win_sum[CNT_W-1:0];
    end else if (ctl.pulse && slot_cnt_r != CNT_MAX) begin
      slot_cnt_nxt = slot_cnt_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= '0;
      hist_sum_r <= '0;
      last_sum_r <= '0;
    end else begin
      slot_cnt_r <= slot_cnt_nxt;
      hist_sum_r <= hist_sum_nxt;
      last_sum_r <= sum_nxt;
    end
  end

  `FPWR_ASSERT_NEXT(a_tick_clears_slot, ctl.tick, slot_cnt_r == '0)
  `FPWR_ASSERT_NEXT(a_sum_held_off_tick, rst_n && !ctl.tick, $stable(last_sum_r))
  `FPWR_ASSERT_NEXT(a_slot_saturates, ctl.pulse && slot_cnt_r == CNT_MAX,
                    slot_cnt_r == CNT_MAX)
  `FPWR_ASSERT_NOW(a_hist_sum_bound, hist_sum_r <= HSUM_W'(HIST_DEPTH * 255))
endmodule
`default_nettype wire

[sv/flow_pulse_window_rate_unit.sv]
`default_nettype none
`include "flow_pulse_window_rate_unit_defines.svh"
// Flow-meter front end. Every beat accepted on in_ch (pulse, window tick,
// budget load or spare code) gives exactly one beat on out_ch, via the
// stage-one and output registers; one beat is accepted per cycle back to
// back while the output is not stalled. The history of closed slots lives
// in a chain of shift cells with a running sum beside it, so a tick costs
// a single add and subtract. The second stage maps the saturated window
// sum through the two flow tables into the output register. in_ch.ready
// falls only when both stages hold beats the sink has not taken.
module flow_pulse_window_rate_unit (
  input  wire        clk,
  input  wire        rst_n,
  fpwr_in_if.sink    in_ch,
  fpwr_out_if.source out_ch
);
  import fpwr_pkg::*;

  logic              fire;
  logic              s1_adv;
  logic              s2_adv;
  fpwr_win_ctl_t     win_ctl;
  logic [CNT_W-1:0]  sum_nxt;

  logic [FILL_W-1:0] budget_r;
  logic [FILL_W-1:0] budget_nxt;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [CNT_W-1:0]  s1_sum_r;
  logic [FILL_W-1:0] s1_fill_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CNT_W-1:0]  out_pps_r;
  logic [RATE_W-1:0] out_rate_r;
  logic [HOT_W-1:0]  out_hot_r;
  logic [FILL_W-1:0] out_fill_r;

  assign s2_adv      = !out_valid_r || out_ch.ready;
  assign s1_adv      = !s1_valid_r || s2_adv;
  assign in_ch.ready = s1_adv;
  assign fire        = in_ch.valid && s1_adv;

  assign win_ctl.pulse = fire && (in_ch.operation == OP_PULSE);
  assign win_ctl.tick  = fire && (in_ch.operation == OP_TICK);

  fpwr_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .sum_nxt (sum_nxt)
  );

  always_comb begin
    budget_nxt = budget_r;
    if (fire) begin
      case (in_ch.operation)
        OP_PULSE: begin
          if (in_ch.tray_filling_active && !in_ch.hot_dispensing &&
              in_ch.tray_pump_on && budget_r != '0) begin
            budget_nxt = budget_r - 16'd1;
          end
        end
        OP_LOAD:  budget_nxt = in_ch.fill_value;
        default:  budget_nxt = budget_r;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_adv ? fire : s1_valid_r;
    out_valid_nxt = s2_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      budget_r    <= budget_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_sum_r  <= sum_nxt;
      s1_fill_r <= budget_nxt;
    end
    if (s2_adv && s1_valid_r) begin
      out_pps_r  <= s1_sum_r;
      out_rate_r <= rate_tenths(s1_sum_r);
      out_hot_r  <= hot_rate(s1_sum_r);
      out_fill_r <= s1_fill_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.pulses_per_second = out_pps_r;
  assign out_ch.flow_tenths_lpm   = out_rate_r;
  assign out_ch.hot_flow_value    = out_hot_r;
  assign out_ch.fill_remaining    = out_fill_r;

  `FPWR_ASSERT_NEXT(a_budget_no_rise, rst_n && !(fire && in_ch.operation == OP_LOAD),
                    budget_r <= $past(budget_r))
  `FPWR_ASSERT_NEXT(a_budget_step, rst_n && !(fire && in_ch.operation == OP_LOAD),
                    ($past(budget_r) - budget_r) <= 16'd1)
  `FPWR_ASSERT_NEXT(a_s1_holds, rst_n && s1_valid_r && !s2_adv,
                    s1_valid_r && $stable(s1_sum_r) && $stable(s1_fill_r))
endmodule
`default_nettype wire

[verif/flow_pulse_window_rate_unit_tb.sv]
`default_nettype none
module flow_pulse_window_rate_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpwr_pkg::*;

  // the op encoding has no name for the fourth code, which must leave state alone
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [CNT_W-1:0]  pps;
    logic [RATE_W-1:0] rate;
    logic [HOT_W-1:0]  hot;
    logic [FILL_W-1:0] fill;
  } flow_report_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  fpwr_in_if  in_ch ();
  fpwr_out_if out_ch ();

  flow_pulse_window_rate_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  flow_report_t expected_reports[$];
  flow_report_t head_rep;

  // shadow of the block's counting state
  logic [CNT_W-1:0]  cur_slot;
  logic [CNT_W-1:0]  closed_slots[HIST_DEPTH];
  logic [CNT_W-1:0]  window_sum;
  logic [FILL_W-1:0] pulse_budget;

  function automatic int unsigned flow_tenths_of(input int unsigned hz);
    if (hz < 5) return 0;
    if (hz < 10) return 1;
    if (hz >= 118) return 20;
    return 2 + (hz - 10) / 6;
  endfunction

  function automatic int unsigned hot_flow_of(input int unsigned hz);
    int unsigned k;
    k = hz - 16;
    if (hz < 5) return 0;
    if (hz < 10) return 100;
    if (hz < 16) return 200;
    // six steps per hundred: +20 each for five, then the sixth lands on +90
    if (hz < 40) return 300 + 100 * (k / 6) + ((k % 6) < 5 ? 20 * (k % 6) : 90);
    if (hz >= 118) return 2000;
    return 700 + 100 * ((hz - 40) / 6);
  endfunction

  function automatic int unsigned history_total();
    int unsigned acc;
    acc = 0;
    foreach (closed_slots[i]) acc += closed_slots[i];
    return acc;
  endfunction

  task automatic predict_item(input logic [OP_W-1:0] op, input logic [FILL_W-1:0] fill,
                              input logic filling, input logic hot, input logic pump);
    int unsigned total;
    flow_report_t rep;
    case (op)
      OP_PULSE: begin
        if (cur_slot != CNT_MAX) cur_slot = cur_slot + 1'b1;
        if (filling && !hot && pump && pulse_budget != 0) pulse_budget = pulse_budget - 1'b1;
      end
      OP_TICK: begin
        total = cur_slot + history_total();
        window_sum = (total > 255) ? CNT_MAX : CNT_W'(total);
        for (int i = HIST_DEPTH - 1; i > 0; i--) closed_slots[i] = closed_slots[i-1];
        closed_slots[0] = cur_slot;
        cur_slot = '0;
      end
      OP_LOAD: pulse_budget = fill;
      default: ;
    endcase
    rep.pps  = window_sum;
    rep.rate = RATE_W'(flow_tenths_of(window_sum));
    rep.hot  = HOT_W'(hot_flow_of(window_sum));
    rep.fill = pulse_budget;
    expected_reports.push_back(rep);
  endtask

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [FILL_W-1:0] fill,
                           input logic filling, input logic hot, input logic pump);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid               <= 1'b1;
    in_ch.operation           <= op;
    in_ch.fill_value          <= fill;
    in_ch.tray_filling_active <= filling;
    in_ch.hot_dispensing      <= hot;
    in_ch.tray_pump_on        <= pump;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(op, fill, filling, hot, pump);
  endtask

  task automatic send_pulse(input bit fill_ok);
    logic [2:0] cond;
    cond = fill_ok ? 3'b101 : 3'($urandom_range(7));
    send_item(OP_PULSE, FILL_W'($urandom_range(16'hFFFF)), cond[2], cond[1], cond[0]);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, FILL_W'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic send_load(input logic [FILL_W-1:0] value);
    send_item(OP_LOAD, value, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
  endtask

  task automatic test_directed_edges();
    logic [2:0] cond;
    send_item(OP_PULSE, 16'hFFFF, 1'b1, 1'b0, 1'b1);  // empty budget holds at zero
    send_load(16'd3);
    cond = '0;
    repeat (8) begin
      send_item(OP_PULSE, 16'h0000, cond[2], cond[1], cond[0]);
      cond = cond + 1'b1;
    end
    repeat (3) send_item(OP_PULSE, 16'h0000, 1'b1, 1'b0, 1'b1);
    send_load(16'hFFFF);
    send_item(OP_PULSE, 16'h0000, 1'b1, 1'b0, 1'b1);
    send_item(OP_SPARE, 16'h1234, 1'b1, 1'b0, 1'b1);
    send_item(OP_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_item(OP_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_item(OP_SPARE, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_load(16'h0000);
  endtask

  task automatic test_count_saturation();
    repeat (260) send_pulse($urandom_range(1));
    send_tick();  // slot clamps at full count
    repeat (WINDOW_SLOTS) begin
      repeat (30) send_pulse($urandom_range(1));
      send_tick();  // window total runs past 255
    end
    repeat (WINDOW_SLOTS) send_tick();  // window drains back to zero
  endtask

  // ascending targets are always reachable: the nine kept slots never exceed the last sum
  task automatic test_rate_thresholds();
    int unsigned targets[$] = {0, 4, 5, 9, 10, 15, 16, 17, 21, 22, 39, 40, 45, 46,
                               51, 52, 111, 112, 117, 118, 119, 254, 255};
    int unsigned hist;
    foreach (targets[t]) begin
      hist = history_total();
      repeat ((targets[t] > hist) ? targets[t] - hist : 0) send_pulse($urandom_range(1));
      send_tick();
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0, 1: send_load(FILL_W'($urandom_range(40)));
      2:    send_load(FILL_W'($urandom_range(16'hFFFF)));
      default: send_item(OP_SPARE, FILL_W'($urandom_range(16'hFFFF)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
    endcase
  endtask

  // each slot is filled so its window total is the larger of a target and the history
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned target;
    int unsigned hist;
    sent = 0;
    while (sent < n_items) begin
      target = ($urandom_range(9) == 0) ? $urandom_range(400) : $urandom_range(140);
      hist   = history_total();
      repeat ((target > hist) ? target - hist : 0) begin
        if ($urandom_range(15) == 0) begin
          send_noise();
          sent++;
        end
        send_pulse($urandom_range(99) < 60);
        sent++;
      end
      send_tick();
      sent++;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with nothing outstanding");
        mismatch_count++;
      end else begin
        head_rep = expected_reports.pop_front();
        check_field("pulses_per_second", head_rep.pps, out_ch.pulses_per_second);
        check_field("flow_tenths_lpm", head_rep.rate, out_ch.flow_tenths_lpm);
        check_field("hot_flow_value", head_rep.hot, out_ch.hot_flow_value);
        check_field("fill_remaining", head_rep.fill, out_ch.fill_remaining);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("flow_pulse_window_rate_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n                     <= 1'b0;
    in_ch.valid               <= 1'b0;
    in_ch.operation           <= OP_PULSE;
    in_ch.fill_value          <= '0;
    in_ch.tray_filling_active <= 1'b0;
    in_ch.hot_dispensing      <= 1'b0;
    in_ch.tray_pump_on        <= 1'b0;
    cur_slot     = '0;
    window_sum   = '0;
    pulse_budget = '0;
    foreach (closed_slots[i]) closed_slots[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    sink_stall_pct = 86;
    test_count_saturation();
    send_idle_pct  = 30;
    sink_stall_pct = 30;
    test_rate_thresholds();

    send_idle_pct  = 0;
    sink_stall_pct = 0;
    test_random_traffic(50);
    send_idle_pct = 86;
    test_random_traffic(50);
    send_idle_pct  = 0;
    sink_stall_pct = 86;
    test_random_traffic(50);
    send_idle_pct  = 30;
    sink_stall_pct = 30;
    test_random_traffic(50);

    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("flow_pulse_window_rate_unit_tb: PASS");
    end else begin
      $display("flow_pulse_window_rate_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
